// ----- src/boolean_parenthesization_counter_macros.svh -----
// Assertion macros shared by the counter RTL.
`ifndef BOOLEAN_PARENTHESIZATION_COUNTER_MACROS_SVH
`define BOOLEAN_PARENTHESIZATION_COUNTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BPC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bpc_pkg.sv -----
// Package: sizes, operator codes and sequencer states of the counter.
package bpc_pkg;

  localparam int MAX_OPERANDS = 16;
  localparam int IDX_W        = $clog2(MAX_OPERANDS);
  localparam int CNT_W        = $clog2(MAX_OPERANDS + 1);
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int CNT_VAL_W    = 64;

  typedef enum logic [1:0] {
    OP_AND = 2'd0,
    OP_OR  = 2'd1,
    OP_XOR = 2'd2
  } op_code_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_DIAG,
    S_RD,
    S_MUL,
    S_DRAIN,
    S_WR,
    S_FIN_RD,
    S_FIN
  } state_t;

endpackage

// ----- src/boolean_parenthesization_counter.sv -----
// Operands load one per accepted transfer; the last one starts the count, which writes
//   the n diagonal entries, then per split point reads, multiplies the four products in
//   three partials each and drains, writes each span, and ends with a final read and output.
// One expression at a time; the shared 32x32 multiplier sets the rate.
// Reset (rst, synchronous, active high) clears the sequencer, counts and output valid;
//   the span table needs no clearing, every entry is written before it is read.
`include "boolean_parenthesization_counter_macros.svh"

module boolean_parenthesization_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] operand_bit, [2:1] operator_code, rest zero
  input  logic        s_tlast,   // last_operand
  input  logic [0:0]  s_tuser,   // [0] want_true
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] combination_count
  output logic [0:0]  m_tuser    // [0] overflow_error
);
  import bpc_pkg::*;

  // Span table: one entry per (i,j), true count high half, false count low half.
  logic [2*CNT_VAL_W-1:0] span_mem [1 << ADDR_W];
  logic [2*CNT_VAL_W-1:0] rd_a, rd_b;
  logic [ADDR_W-1:0]      addr_a, addr_b, wr_addr;
  logic [2*CNT_VAL_W-1:0] wr_data;
  logic                   rd_en, wr_en;

  // Operand and operator stores, written in arrival order.
  logic                   opnd_store [MAX_OPERANDS];
  logic [1:0]             oper_store [MAX_OPERANDS];

  state_t                 state, state_next;
  logic [CNT_W-1:0]       cnt;
  logic                   too_many;
  logic [IDX_W-1:0]       nm1;     // index of last operand
  logic                   want;
  logic [IDX_W-1:0]       i, j, k;
  logic [1:0]             pidx, part;
  logic                   acc_clr;

  // Multiplier pipeline
  logic [CNT_VAL_W-1:0]   lt, lf, rt, rf, mul_a, mul_b;
  logic [31:0]            mul_x, mul_y;
  logic [63:0]            mul_p, contrib;
  logic                   to_true;
  logic [CNT_VAL_W-1:0]   prod_val;
  logic                   prod_vld, prod_t;
  logic [CNT_VAL_W-1:0]   t_acc, f_acc;

  logic                   in_xfer, out_free, ovf_now, mul_last;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ovf_now  = too_many || (cnt == CNT_W'(MAX_OPERANDS));
  assign mul_last = (pidx == 2'd3) && (part == 2'd2);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:   if (in_xfer && s_tlast && !ovf_now) state_next = S_DIAG;
      S_DIAG: begin
        if (i == nm1) state_next = (nm1 == '0) ? S_FIN_RD : S_RD;
      end
      S_RD:     state_next = S_MUL;
      S_MUL:    if (mul_last) state_next = S_DRAIN;
      S_DRAIN:  state_next = (k == j - IDX_W'(1)) ? S_WR : S_RD;
      S_WR: begin
        if (j == nm1 && i == '0) state_next = S_FIN_RD;
        else state_next = S_RD;
      end
      S_FIN_RD: state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_LOAD;
      default:  state_next = S_LOAD;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    acc_clr  = 1'b0;
    addr_a   = {i, k};
    addr_b   = {k + IDX_W'(1), j};
    wr_addr  = {i, j};
    wr_data  = {t_acc, f_acc};
    unique case (state)
      S_LOAD:   s_tready = out_free;
      S_DIAG: begin
        wr_en   = 1'b1;
        wr_addr = {i, i};
        wr_data = {{(CNT_VAL_W-1){1'b0}}, opnd_store[i],
                   {(CNT_VAL_W-1){1'b0}}, !opnd_store[i]};
        acc_clr = 1'b1;
      end
      S_RD:     rd_en = 1'b1;
      S_WR: begin
        wr_en   = 1'b1;
        acc_clr = 1'b1;
      end
      S_FIN_RD: begin
        rd_en  = 1'b1;
        addr_a = {{IDX_W{1'b0}}, nm1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  // Operand intake
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      too_many <= 1'b0;
    end else if (in_xfer) begin
      if (s_tlast) begin
        cnt      <= '0;
        too_many <= 1'b0;
      end else if (ovf_now) begin
        too_many <= 1'b1;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && !ovf_now) begin
      opnd_store[cnt[IDX_W-1:0]] <= s_tdata[0];
      oper_store[cnt[IDX_W-1:0]] <= s_tdata[2:1];
    end
    if (in_xfer && s_tlast) begin
      nm1  <= cnt[IDX_W-1:0];
      want <= s_tuser[0];
    end
  end

  // Span / split indices
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD:  i <= '0;
      S_DIAG: begin
        if (i == nm1) begin
          i <= nm1 - IDX_W'(1);
          j <= nm1;
          k <= nm1 - IDX_W'(1);
        end else begin
          i <= i + IDX_W'(1);
        end
      end
      S_DRAIN: if (k != j - IDX_W'(1)) k <= k + IDX_W'(1);
      S_WR: begin
        if (j == nm1) begin
          if (i != '0) begin
            i <= i - IDX_W'(1);
            j <= i;
            k <= i - IDX_W'(1);
          end
        end else begin
          j <= j + IDX_W'(1);
          k <= i;
        end
      end
      default: ;
    endcase
  end

  // Table memory, one write and two reads per cycle
  always_ff @(posedge clk) begin
    if (wr_en) span_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= span_mem[addr_a];
      rd_b <= span_mem[addr_b];
    end
  end

  // Multiply slots: four products, each as three 32x32 partials mod 2^64
  assign lt    = rd_a[2*CNT_VAL_W-1:CNT_VAL_W];
  assign lf    = rd_a[CNT_VAL_W-1:0];
  assign rt    = rd_b[2*CNT_VAL_W-1:CNT_VAL_W];
  assign rf    = rd_b[CNT_VAL_W-1:0];
  assign mul_a = pidx[1] ? lf : lt;
  assign mul_b = pidx[0] ? rf : rt;
  assign mul_x = (part == 2'd2) ? mul_a[63:32] : mul_a[31:0];
  assign mul_y = (part == 2'd1) ? mul_b[63:32] : mul_b[31:0];
  assign mul_p = 64'(mul_x) * 64'(mul_y);
  assign contrib = (part == 2'd0) ? mul_p : {mul_p[31:0], 32'd0};

  // Route product: lt*rt, lt*rf, lf*rt, lf*rf by pidx
  always_comb begin
    unique case (oper_store[k])
      OP_AND:  to_true = (pidx == 2'd0);
      OP_OR:   to_true = (pidx != 2'd3);
      default: to_true = (pidx == 2'd1) || (pidx == 2'd2);  // xor, and code three
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pidx     <= '0;
      part     <= '0;
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (state == S_MUL);
      if (state == S_MUL) begin
        if (part == 2'd2) begin
          part <= '0;
          pidx <= pidx + 2'd1;
        end else begin
          part <= part + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_val <= contrib;
    prod_t   <= to_true;
  end

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      t_acc <= '0;
      f_acc <= '0;
    end else if (prod_vld) begin
      if (prod_t) t_acc <= t_acc + prod_val;
      else        f_acc <= f_acc + prod_val;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_LOAD && in_xfer && s_tlast && ovf_now) begin
      m_tvalid <= 1'b1;
    end else if (state == S_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_xfer && s_tlast && ovf_now) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
    end else if (state == S_FIN && out_free) begin
      m_tdata <= want ? rd_a[2*CNT_VAL_W-1:CNT_VAL_W] : rd_a[CNT_VAL_W-1:0];
      m_tuser <= 1'b0;
    end
  end

  `BPC_ASSERT_NOW(a_split_range, state == S_RD, (k >= i) && (k < j), "split outside span")
  `BPC_ASSERT_NOW(a_span_order, state == S_WR, i < j, "span write with i >= j")
  `BPC_ASSERT_NEXT(a_drain_empty, state == S_DRAIN, !prod_vld, "product left after drain")
  `BPC_ASSERT_NOW(a_ovf_zero, m_tvalid && m_tuser[0], m_tdata == '0, "overflow with count")

endmodule
